FILE: rtl/assert_macros.svh
// Assertion macros for the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("trc assertion failed");

// A condition that must be followed by another one in the next cycle.
`define TRC_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("trc assertion failed");

`endif

FILE: rtl/trc_pkg.sv
// Package with shared types, opcodes and constants of the toy processor core.
`default_nettype none
package trc_pkg;

    // Memory size; it must be a power of two so that addresses wrap by masking.
    localparam int MEM_BYTES = 65536;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int REG_COUNT = 16;
    localparam int REG_IDX_W = $clog2(REG_COUNT);

    // Result status codes.
    localparam logic [1:0] ST_LOADED = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_HALT   = 2'd2;
    localparam logic [1:0] ST_FAULT  = 2'd3;

    // Opcodes.
    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_MOV  = 8'h01;
    localparam logic [7:0] OP_ADD  = 8'h03;
    localparam logic [7:0] OP_SUB  = 8'h04;
    localparam logic [7:0] OP_AND  = 8'h05;
    localparam logic [7:0] OP_OR   = 8'h06;
    localparam logic [7:0] OP_XOR  = 8'h07;
    localparam logic [7:0] OP_NOT  = 8'h08;
    localparam logic [7:0] OP_LD   = 8'h09;
    localparam logic [7:0] OP_ST   = 8'h0A;
    localparam logic [7:0] OP_JMP  = 8'h0C;
    localparam logic [7:0] OP_JZ   = 8'h0E;
    localparam logic [7:0] OP_JNZ  = 8'h10;
    localparam logic [7:0] OP_INT  = 8'h11;
    localparam logic [7:0] OP_HLT  = 8'h12;
    localparam logic [7:0] OP_SHL  = 8'h13;
    localparam logic [7:0] OP_SHR  = 8'h14;
    localparam logic [7:0] OP_PSH  = 8'h15;
    localparam logic [7:0] OP_POP  = 8'h16;
    localparam logic [7:0] OP_CALL = 8'h17;
    localparam logic [7:0] OP_RET  = 8'h18;
    localparam logic [7:0] OP_LW   = 8'h19;
    localparam logic [7:0] OP_SW   = 8'h1A;
    localparam logic [7:0] OP_CMP  = 8'h20;

    // Service numbers of the INT instruction.
    localparam logic [15:0] SVC_PUTCHAR = 16'd1;
    localparam logic [15:0] SVC_GETCHAR = 16'd2;
    localparam logic [15:0] SVC_MAGIC   = 16'd3;
    localparam logic [15:0] MAGIC_VALUE = 16'h1001;
    localparam logic [15:0] SP_RESET    = 16'hC000;

    // One queued item, already classified by the front end.
    typedef struct packed {
        logic        is_load;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  char_in;
    } trc_item_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic      valid;
        trc_item_t item;
    } trc_head_t;

    // Wrap a 16-bit byte address onto the memory.
    function automatic logic [ADDR_W-1:0] mem_addr(input logic [15:0] a);
        return a[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/trc_if.sv
// Channel interfaces for request and response transactions.
`default_nettype none
interface trc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] load_address;
    logic [7:0]  load_byte;
    logic [7:0]  char_in;

    modport source (output valid, output req_type, output load_address,
                    output load_byte, output char_in, input ready);
    modport sink   (input valid, input req_type, input load_address,
                    input load_byte, input char_in, output ready);
endinterface

interface trc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        char_out_valid;
    logic [7:0]  char_out;
    logic [15:0] pc_value;

    modport source (output valid, output status, output char_out_valid,
                    output char_out, output pc_value, input ready);
    modport sink   (input valid, input status, input char_out_valid,
                    input char_out, input pc_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/trc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module trc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/trc_front.sv
// Front end: accepts request transactions, classifies them and queues them.
`default_nettype none
module trc_front
    import trc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    trc_req_if.sink   req,
    input  wire logic pop,
    output trc_head_t head
);

    trc_item_t   ent_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    logic        do_pop;
    trc_item_t   new_item;

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign do_pop    = pop && (cnt_reg != 2'd0);

    // Classify the incoming transaction.
    always_comb
    begin
        new_item.is_load = !req.req_type;
        new_item.addr    = req.load_address;
        new_item.data    = req.load_byte;
        new_item.char_in = req.char_in;
    end

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next = push ? !wptr_reg : wptr_reg;
        rptr_next = do_pop ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= new_item;
        end
    end

    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = ent_reg[rptr_reg];

endmodule
`default_nettype wire

FILE: rtl/trc_back.sv
// Back end: fetches and executes instructions, writes memory, drives responses.
`default_nettype none
module trc_back
    import trc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  trc_head_t head,
    output logic      pop,
    trc_rsp_if.source rsp
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_F0   = 4'd1;
    localparam logic [3:0] S_F1   = 4'd2;
    localparam logic [3:0] S_F2   = 4'd3;
    localparam logic [3:0] S_F3   = 4'd4;
    localparam logic [3:0] S_F4   = 4'd5;
    localparam logic [3:0] S_EX   = 4'd6;
    localparam logic [3:0] S_WH   = 4'd7;
    localparam logic [3:0] S_WL   = 4'd8;
    localparam logic [3:0] S_R0   = 4'd9;
    localparam logic [3:0] S_R1   = 4'd10;
    localparam logic [3:0] S_R2   = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    // Run state codes.
    localparam logic [1:0] RUN_GO    = 2'd0;
    localparam logic [1:0] RUN_HALT  = 2'd1;
    localparam logic [1:0] RUN_FAULT = 2'd2;

    logic [3:0]  state_reg, state_next;
    logic [15:0] pc_reg, pc_next;
    logic [15:0] sp_reg, sp_next;
    logic        zf_reg, zf_next;
    logic        sf_reg, sf_next;
    logic [1:0]  run_reg, run_next;
    logic [31:0] ir_reg, ir_next;
    logic [15:0] ra_reg, ra_next;
    logic [15:0] rb_reg, rb_next;
    logic [7:0]  hi_reg, hi_next;
    logic [15:0] maddr_reg, maddr_next;
    logic [15:0] wdata_reg, wdata_next;
    logic        word_reg, word_next;
    logic        ret_reg, ret_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic        res_cv_reg, res_cv_next;
    logic [7:0]  res_cout_reg, res_cout_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic        out_cv_reg, out_cv_next;
    logic [7:0]  out_cout_reg, out_cout_next;
    logic [15:0] out_pc_reg, out_pc_next;
    logic [REG_COUNT-1:0] rf_vld_reg, rf_vld_next;
    logic        rf_rvld_reg;

    // Memory and register file ports.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic                 rf_we;
    logic [REG_IDX_W-1:0] rf_waddr, rf_raddr;
    logic [15:0]          rf_wdata, rf_rdata, rf_rd;

    // Decoded fields and datapath values.
    logic [7:0]           op;
    logic [REG_IDX_W-1:0] fa, fb;
    logic [15:0]          imm;
    logic [15:0]          sum_all, diff_all, rb_imm, alu_res, shamt, load_val;
    logic                 slot_free;

    trc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    trc_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_rf (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    // A register never written reads as zero.
    assign rf_rd = rf_rvld_reg ? rf_rdata : 16'h0000;

    assign op        = ir_reg[31:24];
    assign fa        = ir_reg[23:20];
    assign fb        = ir_reg[19:16];
    assign imm       = ir_reg[15:0];
    assign sum_all   = ra_reg + rb_reg + imm;
    assign diff_all  = ra_reg - rb_reg - imm;
    assign rb_imm    = rb_reg + imm;
    assign shamt     = rb_imm;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign load_val  = word_reg ? {hi_reg, mem_rdata} : {8'h00, mem_rdata};

    // Result value of the ALU operations that write a register or, for CMP, only set the flags.
    always_comb
    begin
        unique case (op)
            OP_MOV:  alu_res = rb_imm;
            OP_ADD:  alu_res = sum_all;
            OP_SUB:  alu_res = diff_all;
            OP_AND:  alu_res = ra_reg & rb_imm;
            OP_OR:   alu_res = ra_reg | rb_reg;
            OP_XOR:  alu_res = ra_reg ^ rb_reg;
            OP_NOT:  alu_res = ~rb_reg;
            OP_SHL:  alu_res = (shamt[15:4] != 12'd0) ? 16'h0000 : (ra_reg << shamt[3:0]);
            OP_SHR:  alu_res = (shamt[15:4] != 12'd0) ? 16'h0000 : (ra_reg >> shamt[3:0]);
            OP_CMP:  alu_res = diff_all;
            default: alu_res = 16'h0000;
        endcase
    end

    // Sequencer: one item at a time from the queue head.
    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        sp_next         = sp_reg;
        zf_next         = zf_reg;
        sf_next         = sf_reg;
        run_next        = run_reg;
        ir_next         = ir_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        hi_next         = hi_reg;
        maddr_next      = maddr_reg;
        wdata_next      = wdata_reg;
        word_next       = word_reg;
        ret_next        = ret_reg;
        res_status_next = res_status_reg;
        res_cv_next     = res_cv_reg;
        res_cout_next   = res_cout_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_cv_next     = out_cv_reg;
        out_cout_next   = out_cout_reg;
        out_pc_next     = out_pc_reg;
        rf_vld_next     = rf_vld_reg;
        mem_we          = 1'b0;
        mem_waddr       = mem_addr(maddr_reg);
        mem_wdata       = wdata_reg[7:0];
        mem_raddr       = mem_addr(pc_reg);
        rf_we           = 1'b0;
        rf_waddr        = fa;
        rf_wdata        = alu_res;
        rf_raddr        = fa;
        pop             = 1'b0;

        // Output register empties when the consumer takes the transaction.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                res_cv_next   = 1'b0;
                res_cout_next = 8'h00;
                if (head.valid)
                begin
                    priority if (head.item.is_load)
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = mem_addr(head.item.addr);
                        mem_wdata       = head.item.data;
                        res_status_next = ST_LOADED;
                        state_next      = S_DONE;
                    end
                    else if (run_reg == RUN_HALT)
                    begin
                        res_status_next = ST_HALT;
                        state_next      = S_DONE;
                    end
                    else if (run_reg == RUN_FAULT)
                    begin
                        res_status_next = ST_FAULT;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        res_status_next = ST_EXEC;
                        state_next      = S_F0;
                    end
                end
            end
            S_F0:
            begin
                mem_raddr  = mem_addr(pc_reg);
                state_next = S_F1;
            end
            S_F1:
            begin
                mem_raddr            = mem_addr(pc_reg + 16'd1);
                ir_next[31:24]       = mem_rdata;
                state_next           = S_F2;
            end
            S_F2:
            begin
                mem_raddr      = mem_addr(pc_reg + 16'd2);
                ir_next[23:16] = mem_rdata;
                rf_raddr       = mem_rdata[7:4];
                state_next     = S_F3;
            end
            S_F3:
            begin
                mem_raddr     = mem_addr(pc_reg + 16'd3);
                ir_next[15:8] = mem_rdata;
                rf_raddr      = fb;
                ra_next       = rf_rd;
                state_next    = S_F4;
            end
            S_F4:
            begin
                ir_next[7:0] = mem_rdata;
                rf_raddr     = REG_IDX_W'(1);
                rb_next      = rf_rd;
                state_next   = S_EX;
            end
            S_EX:
            begin
                pc_next    = pc_reg + 16'd4;
                state_next = S_DONE;
                word_next  = 1'b1;
                ret_next   = 1'b0;
                unique case (op)
                    OP_NOP:
                    begin
                    end
                    OP_MOV, OP_SHL, OP_SHR:
                    begin
                        rf_we = 1'b1;
                    end
                    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOT:
                    begin
                        rf_we   = 1'b1;
                        zf_next = (alu_res == 16'h0000);
                        sf_next = alu_res[15];
                    end
                    OP_CMP:
                    begin
                        zf_next = (alu_res == 16'h0000);
                        sf_next = alu_res[15];
                    end
                    OP_LD:
                    begin
                        maddr_next = rb_imm;
                        word_next  = 1'b0;
                        state_next = S_R0;
                    end
                    OP_LW:
                    begin
                        maddr_next = rb_imm;
                        state_next = S_R0;
                    end
                    OP_ST:
                    begin
                        maddr_next = ra_reg + imm;
                        wdata_next = rb_reg;
                        state_next = S_WL;
                    end
                    OP_SW:
                    begin
                        maddr_next = ra_reg + imm;
                        wdata_next = rb_reg;
                        state_next = S_WH;
                    end
                    OP_JMP:
                    begin
                        pc_next = sum_all;
                    end
                    OP_JZ:
                    begin
                        if (zf_reg)
                        begin
                            pc_next = sum_all;
                        end
                    end
                    OP_JNZ:
                    begin
                        if (!zf_reg)
                        begin
                            pc_next = sum_all;
                        end
                    end
                    OP_INT:
                    begin
                        rf_waddr = REG_IDX_W'(1);
                        priority if (imm == SVC_PUTCHAR)
                        begin
                            res_cv_next   = 1'b1;
                            res_cout_next = rf_rd[7:0];
                        end
                        else if (imm == SVC_GETCHAR)
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = {8'h00, head.item.char_in};
                        end
                        else if (imm == SVC_MAGIC)
                        begin
                            rf_we    = 1'b1;
                            rf_wdata = MAGIC_VALUE;
                        end
                        else
                        begin
                            // Other service numbers do nothing.
                        end
                    end
                    OP_HLT:
                    begin
                        pc_next         = pc_reg;
                        run_next        = RUN_HALT;
                        res_status_next = ST_HALT;
                    end
                    OP_PSH:
                    begin
                        sp_next    = sp_reg - 16'd2;
                        maddr_next = sp_reg - 16'd2;
                        wdata_next = ra_reg + imm;
                        state_next = S_WH;
                    end
                    OP_CALL:
                    begin
                        sp_next    = sp_reg - 16'd2;
                        maddr_next = sp_reg - 16'd2;
                        wdata_next = pc_reg;
                        pc_next    = ra_reg + imm;
                        state_next = S_WH;
                    end
                    OP_POP:
                    begin
                        sp_next    = sp_reg + 16'd2;
                        maddr_next = sp_reg;
                        state_next = S_R0;
                    end
                    OP_RET:
                    begin
                        sp_next    = sp_reg + 16'd2;
                        maddr_next = sp_reg;
                        ret_next   = 1'b1;
                        state_next = S_R0;
                    end
                    default:
                    begin
                        pc_next         = pc_reg;
                        run_next        = RUN_FAULT;
                        res_status_next = ST_FAULT;
                    end
                endcase
                if (rf_we)
                begin
                    rf_vld_next[rf_waddr] = 1'b1;
                end
            end
            S_WH:
            begin
                mem_we     = 1'b1;
                mem_wdata  = wdata_reg[15:8];
                maddr_next = maddr_reg + 16'd1;
                state_next = S_WL;
            end
            S_WL:
            begin
                mem_we     = 1'b1;
                mem_wdata  = wdata_reg[7:0];
                state_next = S_DONE;
            end
            S_R0:
            begin
                mem_raddr  = mem_addr(maddr_reg);
                maddr_next = maddr_reg + 16'd1;
                state_next = word_reg ? S_R1 : S_R2;
            end
            S_R1:
            begin
                mem_raddr  = mem_addr(maddr_reg);
                hi_next    = mem_rdata;
                state_next = S_R2;
            end
            S_R2:
            begin
                // Loaded word goes to the program counter or to a register.
                if (ret_reg)
                begin
                    pc_next = load_val + 16'd4;
                end
                else
                begin
                    rf_we             = 1'b1;
                    rf_wdata          = load_val;
                    rf_vld_next[fa]   = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_cv_next     = res_cv_reg;
                    out_cout_next   = res_cout_reg;
                    out_pc_next     = pc_reg;
                    pop             = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= 16'h0000;
            sp_reg        <= SP_RESET;
            zf_reg        <= 1'b0;
            sf_reg        <= 1'b0;
            run_reg       <= RUN_GO;
            out_valid_reg <= 1'b0;
            rf_vld_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            sp_reg        <= sp_next;
            zf_reg        <= zf_next;
            sf_reg        <= sf_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
            rf_vld_reg    <= rf_vld_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        ir_reg         <= ir_next;
        ra_reg         <= ra_next;
        rb_reg         <= rb_next;
        hi_reg         <= hi_next;
        maddr_reg      <= maddr_next;
        wdata_reg      <= wdata_next;
        word_reg       <= word_next;
        ret_reg        <= ret_next;
        res_status_reg <= res_status_next;
        res_cv_reg     <= res_cv_next;
        res_cout_reg   <= res_cout_next;
        out_status_reg <= out_status_next;
        out_cv_reg     <= out_cv_next;
        out_cout_reg   <= out_cout_next;
        out_pc_reg     <= out_pc_next;
        rf_rvld_reg    <= rf_vld_reg[rf_raddr];
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.char_out_valid = out_cv_reg;
    assign rsp.char_out       = out_cout_reg;
    assign rsp.pc_value       = out_pc_reg;

endmodule
`default_nettype wire

FILE: rtl/toy_risc_cpu_core.sv
// Top level: a 16-bit toy processor with a queued front end and an executing back end.
// A load writes its byte and goes straight to its response; a stopped step only answers with its status;
// a running step fetches its instruction, executes it and may then access memory or the stack.
// The back end takes one item at a time, since the byte-wide memory port fetches the four instruction
// bytes one after another; meanwhile the front end queues up to two requests.
// Reset: asynchronous, active low; registers read as zero, SP is 0xC000, memory is undefined.
`default_nettype none
module toy_risc_cpu_core
    import trc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    trc_req_if.sink   req,
    trc_rsp_if.source rsp
);

    trc_head_t head;
    logic      pop;

    trc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .pop   (pop),
        .head  (head)
    );

    trc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire

FILE: rtl/trc_checker.sv
// Port-level checker for the toy processor core and its bind statement.
`default_nettype none
`include "assert_macros.svh"
module trc_checker
    import trc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [1:0]  status,
    input wire logic        char_out_valid,
    input wire logic [7:0]  char_out,
    input wire logic [15:0] pc_value
);

    // A stalled response transaction keeps its program counter and status.
    `TRC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(pc_value) && $stable(status))

    // Only an executed step can emit a character.
    `TRC_ASSERT(a_char_only_exec, clk, rst_n, !(rsp_valid && char_out_valid) || status == ST_EXEC)

    // Without a character the character field is zero.
    `TRC_ASSERT(a_char_zero, clk, rst_n, !(rsp_valid && !char_out_valid) || char_out == 8'h00)

endmodule

bind toy_risc_cpu_core trc_checker u_trc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .status         (rsp.status),
    .char_out_valid (rsp.char_out_valid),
    .char_out       (rsp.char_out),
    .pc_value       (rsp.pc_value)
);
`default_nettype wire
